FILE: sv/shd_pkg.sv
`default_nettype none

package shd_pkg;

	// sync word, first byte on the wire first
	localparam logic [7:0] SYNC_B0 = 8'h53;
	localparam logic [7:0] SYNC_B1 = 8'h59;
	localparam logic [7:0] SYNC_B2 = 8'h4E;
	localparam logic [7:0] SYNC_B3 = 8'h43;

	// result kinds
	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// payload limit after reset, and its third for the raw RGB check
	localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd19999960;
	localparam logic [30:0] MAX_DIV3_RESET    = 31'(MAX_PAYLOAD_RESET / 3);

	// floor(x / 3) == (x * DIV3_RECIP) >> 33 for any 32-bit x
	localparam logic [31:0] DIV3_RECIP = 32'hAAAAAAAB;

	// parser phase
	typedef enum logic [1:0] {
		PH_HUNT    = 2'b01,
		PH_PAYLOAD = 2'b10
	} phase_t;

	// one result beat
	typedef struct packed {
		logic               kind;
		logic [31:0]        frame_width;
		logic [31:0]        frame_height;
		logic [31:0]        fps_bits;
		logic signed [31:0] link_rssi;
		logic               upscale_on;
		logic signed [31:0] good_frames;
		logic signed [31:0] bad_frames;
		logic               interp_enabled;
		logic               interp_ok;
		logic [7:0]         payload_byte;
		logic               last_byte;
	} res_t;

endpackage

`default_nettype wire

FILE: sv/shd_len_chk.sv
`default_nettype none

// Payload length check: compressed mode takes height, raw RGB takes
// width*height*3, both bounded by the configured limit.
module shd_len_chk #(
	parameter bit REG_PROD = 1'b1
) (
	input  wire logic        clk,
	input  wire logic [31:0] mul_w,
	input  wire logic [31:0] mul_h,
	input  wire logic [31:0] hdr_w,
	input  wire logic [31:0] hdr_h,
	input  wire logic [31:0] max_bytes,
	input  wire logic [30:0] max_div3,
	output logic             len_ok,
	output logic [31:0]      len
);
	import shd_pkg::*;

	logic [63:0] prod;

	// product of width and height, registered when the window allows it
	generate
		if (REG_PROD) begin : g_reg
			logic [63:0] prod_s1;
			always_ff @(posedge clk) begin
				prod_s1 <= 64'(mul_w) * 64'(mul_h);
			end
			assign prod = prod_s1;
		end else begin : g_comb
			assign prod = 64'(mul_w) * 64'(mul_h);
		end
	endgenerate

	// limit compare and length
	always_comb begin
		if (hdr_w == 32'd0) begin
			len_ok = (hdr_h != 32'd0) && (hdr_h <= max_bytes);
			len    = hdr_h;
		end else begin
			len_ok = (prod != 64'd0) && (prod <= {33'd0, max_div3});
			len    = prod[31:0] + {prod[30:0], 1'b0};
		end
	end

endmodule

`default_nettype wire

FILE: sv/shd_hunt.sv
`default_nettype none

// Sync hunt, header window and payload pass-through. One input beat is
// fully handled in the cycle it is taken.
module shd_hunt #(
	parameter int HB = 40
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  in_byte,
	input  wire logic [31:0] max_bytes,
	input  wire logic [30:0] max_div3,
	output logic             res_valid,
	output shd_pkg::res_t    res
);
	import shd_pkg::*;

	localparam int FW = $clog2(HB + 1);
	localparam int IW = $clog2(HB);

	// header field offsets
	localparam int OFF_W     = 4;
	localparam int OFF_H     = 8;
	localparam int OFF_FPS   = 12;
	localparam int OFF_RSSI  = 16;
	localparam int OFF_SCALE = 20;
	localparam int OFF_GOOD  = 24;
	localparam int OFF_BAD   = 28;
	localparam int OFF_IEN   = 32;
	localparam int OFF_IOK   = 36;

	// product is registered once bytes 4..11 settle before the last byte
	localparam bit REG_PROD = (HB >= 14);

	logic [HB-1:0][7:0] win_q;
	logic [FW-1:0]      fill_q;
	phase_t             phase_q;
	logic [31:0]        left_q;

	logic [HB-1:0][7:0] app;
	logic [HB-1:0][7:0] drop1;
	logic [HB-1:0][7:0] shft;
	logic [HB-1:0][7:0] win_d;
	logic [FW-1:0]      fill_app;
	logic [FW-1:0]      fill_d;
	phase_t             phase_d;
	logic [31:0]        left_d;
	logic               sync_head;
	logic [HB-1:0]      hit;
	logic [HB-1:0]      first;
	logic [IW-1:0]      sel_hit;
	logic [IW-1:0]      shamt;
	logic [31:0]        w_app;
	logic [31:0]        h_app;
	logic               len_ok;
	logic [31:0]        len;

	// little-endian word, zero when it runs past the header
	function automatic logic [31:0] rd32(input logic [HB-1:0][7:0] w, input int off);
		logic [31:0] r;
		r = '0;
		if (off + 4 <= HB) begin
			for (int k = 0; k < 4; k++) begin
				r[8*k +: 8] = w[IW'(off + k)];
			end
		end
		return r;
	endfunction

	// window with the new byte appended
	always_comb begin
		for (int i = 0; i < HB; i++) begin
			app[i] = (FW'(i) == fill_q) ? in_byte : win_q[i];
		end
	end

	assign fill_app  = fill_q + FW'(1);
	assign sync_head = (app[0] == SYNC_B0) && (app[1] == SYNC_B1) &&
	                   (app[2] == SYNC_B2) && (app[3] == SYNC_B3);
	assign w_app     = rd32(app, OFF_W);
	assign h_app     = rd32(app, OFF_H);

	// sync match at every position past the rejected sync word
	always_comb begin
		hit = '0;
		for (int k = 0; k < HB; k++) begin
			if (k >= 4 && k + 3 < HB) begin
				hit[k] = (app[IW'(k)] == SYNC_B0) && (app[IW'(k + 1)] == SYNC_B1) &&
				         (app[IW'(k + 2)] == SYNC_B2) && (app[IW'(k + 3)] == SYNC_B3);
			end
		end
	end

	// lowest match wins; with none only the last three bytes stay
	assign first = hit & (~hit + HB'(1));
	always_comb begin
		sel_hit = '0;
		for (int k = 0; k < HB; k++) begin
			if (first[k]) begin
				sel_hit = sel_hit | IW'(k);
			end
		end
		shamt = (|hit) ? sel_hit : IW'(HB - 3);
	end

	// shifted windows
	always_comb begin
		logic [IW:0] idx;
		idx = '0;
		for (int i = 0; i < HB; i++) begin
			idx     = (IW + 1)'(i) + (IW + 1)'(shamt);
			shft[i] = (idx < (IW + 1)'(HB)) ? app[idx[IW-1:0]] : 8'h00;
			drop1[i] = (i + 1 < HB) ? app[IW'(i + 1)] : 8'h00;
		end
	end

	shd_len_chk #(
		.REG_PROD (REG_PROD)
	) u_len_chk (
		.clk       (clk),
		.mul_w     (REG_PROD ? rd32(win_q, OFF_W) : w_app),
		.mul_h     (REG_PROD ? rd32(win_q, OFF_H) : h_app),
		.hdr_w     (w_app),
		.hdr_h     (h_app),
		.max_bytes (max_bytes),
		.max_div3  (max_div3),
		.len_ok    (len_ok),
		.len       (len)
	);

	// next state and result for the beat at the input
	always_comb begin
		res       = '0;
		res_valid = 1'b0;
		win_d     = app;
		fill_d    = fill_q;
		phase_d   = phase_q;
		left_d    = left_q;
		case (phase_q)
			PH_PAYLOAD: begin
				res_valid        = 1'b1;
				res.kind         = KIND_PAYLOAD;
				res.payload_byte = in_byte;
				win_d            = win_q;
				if (left_q <= 32'd1) begin
					res.last_byte = 1'b1;
					left_d        = 32'd0;
					phase_d       = PH_HUNT;
				end else begin
					left_d = left_q - 32'd1;
				end
			end
			PH_HUNT: begin
				if (fill_app == FW'(HB) && sync_head) begin
					if (len_ok) begin
						res_valid          = 1'b1;
						res.kind           = KIND_HEADER;
						res.frame_width    = w_app;
						res.frame_height   = h_app;
						res.fps_bits       = rd32(app, OFF_FPS);
						res.link_rssi      = rd32(app, OFF_RSSI);
						res.upscale_on     = (rd32(app, OFF_SCALE) != 32'd0);
						res.good_frames    = rd32(app, OFF_GOOD);
						res.bad_frames     = rd32(app, OFF_BAD);
						res.interp_enabled = (rd32(app, OFF_IEN) != 32'd0);
						res.interp_ok      = (rd32(app, OFF_IOK) != 32'd0);
						left_d             = len;
						phase_d            = PH_PAYLOAD;
						fill_d             = '0;
					end else begin
						win_d  = shft;
						fill_d = FW'(HB) - FW'(shamt);
					end
				end else if (fill_app >= FW'(4) && !sync_head) begin
					win_d  = drop1;
					fill_d = fill_app - FW'(1);
				end else begin
					fill_d = fill_app;
				end
			end
			default: begin
				win_d   = win_q;
				fill_d  = '0;
				phase_d = PH_HUNT;
				left_d  = 32'd0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			phase_q <= PH_HUNT;
			left_q  <= 32'd0;
		end else if (take) begin
			fill_q  <= fill_d;
			phase_q <= phase_d;
			left_q  <= left_d;
		end
	end

	// header window bytes
	always_ff @(posedge clk) begin
		if (take) begin
			win_q <= win_d;
		end
	end

endmodule

`default_nettype wire

FILE: sv/shd_out_buf.sv
`default_nettype none

// Result register with a skid entry behind it.
module shd_out_buf (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire shd_pkg::res_t push_res,
	output logic               ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output shd_pkg::res_t      head_res
);
	import shd_pkg::*;

	logic head_v_q;
	logic skid_v_q;
	res_t head_q;
	res_t skid_q;
	logic pop;

	assign pop       = head_v_q && out_ready;
	assign ready     = !skid_v_q;
	assign out_valid = head_v_q;
	assign head_res  = head_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= push;
			end else begin
				head_v_q <= push;
			end
		end else if (push) begin
			if (head_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				head_v_q <= 1'b1;
			end
		end
	end

	// data
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				head_q <= skid_q;
				if (push) begin
					skid_q <= push_res;
				end
			end else if (push) begin
				head_q <= push_res;
			end
		end else if (push) begin
			if (head_v_q) begin
				skid_q <= push_res;
			end else begin
				head_q <= push_res;
			end
		end
	end

endmodule

`default_nettype wire

FILE: sv/sync_header_frame_deframer.sv
`default_nettype none

// Channel  Handshake              Beat
// cfg      cfg_valid/cfg_ready    cfg_data: max_payload_bytes
// in       in_valid/in_ready      in_byte
// out      out_valid/out_ready    out_kind .. last_byte, one result
//
// One input byte per cycle while in_ready is high; each byte is resolved in
// the cycle it is taken (sync search over the header window runs in
// parallel); out shows any result from the result register, via skid if busy.
// A result register plus one skid entry decouple in from out; in_ready drops
// only while both hold results. cfg_ready is always high.
// Reset is asynchronous, active low; the header window is not cleared.
module sync_header_frame_deframer #(
	parameter int HEADER_BYTES = 40
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             out_kind,
	output logic [31:0]      frame_width,
	output logic [31:0]      frame_height,
	output logic [31:0]      fps_bits,
	output logic signed [31:0] link_rssi,
	output logic             upscale_on,
	output logic signed [31:0] good_frames,
	output logic signed [31:0] bad_frames,
	output logic             interp_enabled,
	output logic             interp_ok,
	output logic [7:0]       payload_byte,
	output logic             last_byte
);
	import shd_pkg::*;

	logic [31:0] max_q;
	logic [30:0] div3_q;
	logic [63:0] cfg_mul;
	logic        take;
	logic        res_valid;
	res_t        res;
	res_t        head_res;

	// limit register, with its third taken at write time
	assign cfg_ready = 1'b1;
	assign cfg_mul   = 64'(cfg_data) * 64'(DIV3_RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q  <= MAX_PAYLOAD_RESET;
			div3_q <= MAX_DIV3_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_q  <= cfg_data;
			div3_q <= cfg_mul[63:33];
		end
	end

	assign take = in_valid && in_ready;

	shd_hunt #(
		.HB (HEADER_BYTES)
	) u_hunt (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.in_byte   (in_byte),
		.max_bytes (max_q),
		.max_div3  (div3_q),
		.res_valid (res_valid),
		.res       (res)
	);

	shd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && res_valid),
		.push_res  (res),
		.ready     (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head_res  (head_res)
	);

	// result fields
	assign out_kind       = head_res.kind;
	assign frame_width    = head_res.frame_width;
	assign frame_height   = head_res.frame_height;
	assign fps_bits       = head_res.fps_bits;
	assign link_rssi      = head_res.link_rssi;
	assign upscale_on     = head_res.upscale_on;
	assign good_frames    = head_res.good_frames;
	assign bad_frames     = head_res.bad_frames;
	assign interp_enabled = head_res.interp_enabled;
	assign interp_ok      = head_res.interp_ok;
	assign payload_byte   = head_res.payload_byte;
	assign last_byte      = head_res.last_byte;

endmodule

`default_nettype wire

FILE: bench/deframer_monitor.sv
// Watches the config, byte and result channels of the deframer, tracks the
// hunt / header / payload state of the stream on its own and compares every
// result beat with the oldest outstanding forecast.
module deframer_monitor #(
	parameter int HEADER_BYTES = 40
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic [31:0]        cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [7:0]         in_byte,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic               out_kind,
	input  wire logic [31:0]        frame_width,
	input  wire logic [31:0]        frame_height,
	input  wire logic [31:0]        fps_bits,
	input  wire logic signed [31:0] link_rssi,
	input  wire logic               upscale_on,
	input  wire logic signed [31:0] good_frames,
	input  wire logic signed [31:0] bad_frames,
	input  wire logic               interp_enabled,
	input  wire logic               interp_ok,
	input  wire logic [7:0]         payload_byte,
	input  wire logic               last_byte,
	output int                      errors,
	output int                      pending,
	output int                      hdr_seen,
	output int                      bytes_seen
);
	import shd_pkg::*;

	// shadow of the parser
	logic [7:0]  win [HEADER_BYTES];
	int          held;
	phase_t      mode;
	logic [31:0] left;
	logic [31:0] ceiling;

	res_t        due [$];
	int          fails;
	int          heads;
	int          data_beats;

	function automatic logic [31:0] word_at(int off);
		if (off + 4 > HEADER_BYTES)
			return 32'h0;
		return {win[off + 3], win[off + 2], win[off + 1], win[off]};
	endfunction

	function automatic bit sync_lead();
		return win[0] == SYNC_B0 && win[1] == SYNC_B1 &&
			win[2] == SYNC_B2 && win[3] == SYNC_B3;
	endfunction

	task automatic shift_out(int n);
		for (int i = 0; i + n < held; i++)
			win[i] = win[i + n];
		held -= n;
	endtask

	// drop the oldest byte until the window opens with the sync word
	task automatic realign();
		while (held >= 4 && !sync_lead())
			shift_out(1);
	endtask

	// one stream byte: pass-through in payload, else grow and test the header
	task automatic absorb_byte(input logic [7:0] b);
		res_t        r;
		logic [31:0] w;
		logic [31:0] h;
		logic [63:0] prod;
		logic [31:0] len;
		bit          ok;
		r = '0;
		if (mode == PH_PAYLOAD) begin
			r.kind = KIND_PAYLOAD;
			r.payload_byte = b;
			if (left <= 32'd1) begin
				r.last_byte = 1'b1;
				left = '0;
				mode = PH_HUNT;
			end else begin
				left = left - 32'd1;
			end
			due.push_back(r);
			return;
		end
		if (held < HEADER_BYTES) begin
			win[held] = b;
			held++;
		end
		realign();
		if (held == HEADER_BYTES && sync_lead()) begin
			w = word_at(4);
			h = word_at(8);
			if (w == 32'd0) begin
				ok = h != 32'd0 && h <= ceiling;
				len = h;
			end else begin
				// exact product, compared against the limit's third
				prod = 64'(w) * 64'(h);
				ok = prod != 64'd0 && prod <= 64'(ceiling / 32'd3);
				len = 32'(prod * 64'd3);
			end
			if (!ok) begin
				shift_out(4);
				realign();
				return;
			end
			r.kind = KIND_HEADER;
			r.frame_width = w;
			r.frame_height = h;
			r.fps_bits = word_at(12);
			r.link_rssi = word_at(16);
			r.upscale_on = word_at(20) != 32'd0;
			r.good_frames = word_at(24);
			r.bad_frames = word_at(28);
			r.interp_enabled = word_at(32) != 32'd0;
			r.interp_ok = word_at(36) != 32'd0;
			due.push_back(r);
			left = len;
			mode = PH_PAYLOAD;
			held = 0;
		end
	endtask

	function automatic void field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			fails++;
			$error("%s: expected %0h, actual %0h", name, want, got);
		end
	endfunction

	task automatic check_beat();
		res_t e;
		if (due.size() == 0) begin
			fails++;
			$error("result beat of kind %0d with nothing expected", out_kind);
			return;
		end
		e = due.pop_front();
		if (e.kind == KIND_HEADER)
			heads++;
		else
			data_beats++;
		field("out_kind", e.kind, out_kind);
		field("frame_width", e.frame_width, frame_width);
		field("frame_height", e.frame_height, frame_height);
		field("fps_bits", e.fps_bits, fps_bits);
		field("link_rssi", e.link_rssi, link_rssi);
		field("upscale_on", e.upscale_on, upscale_on);
		field("good_frames", e.good_frames, good_frames);
		field("bad_frames", e.bad_frames, bad_frames);
		field("interp_enabled", e.interp_enabled, interp_enabled);
		field("interp_ok", e.interp_ok, interp_ok);
		field("payload_byte", e.payload_byte, payload_byte);
		field("last_byte", e.last_byte, last_byte);
	endtask

	// all three channels sampled on the same edge as the block; a limit
	// written on this edge applies from the next byte on
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			mode = PH_HUNT;
			left = '0;
			ceiling = MAX_PAYLOAD_RESET;
			due.delete();
			fails = 0;
			heads = 0;
			data_beats = 0;
		end else begin
			if (out_valid && out_ready)
				check_beat();
			if (in_valid && in_ready)
				absorb_byte(in_byte);
			if (cfg_valid && cfg_ready)
				ceiling = cfg_data;
		end
		errors <= fails;
		pending <= due.size();
		hdr_seen <= heads;
		bytes_seen <= data_beats;
	end

endmodule

FILE: bench/sync_header_frame_deframer_tb.sv
module sync_header_frame_deframer_tb;
	import shd_pkg::*;

	localparam int HEADER_BYTES = 40;
	localparam int RANDOM_BYTES = 1000;
	localparam int CYCLE_LIMIT  = 400000;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_COMB
	} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [31:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         in_byte = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               out_kind;
	logic [31:0]        frame_width;
	logic [31:0]        frame_height;
	logic [31:0]        fps_bits;
	logic signed [31:0] link_rssi;
	logic               upscale_on;
	logic signed [31:0] good_frames;
	logic signed [31:0] bad_frames;
	logic               interp_enabled;
	logic               interp_ok;
	logic [7:0]         payload_byte;
	logic               last_byte;

	int                 errors;
	int                 pending;
	int                 hdr_seen;
	int                 bytes_seen;

	int                 cycles = 0;
	logic [31:0]        limit_now = MAX_PAYLOAD_RESET;
	int                 limits_written = 0;
	int                 pushed = 0;
	int                 burst_left = 0;
	bit                 steady = 1'b0;
	logic [7:0]         tx_q [$];
	rx_mode_t           rx_mode = RX_OPEN;
	logic [31:0]        rx_tick = '0;

	sync_header_frame_deframer #(.HEADER_BYTES(HEADER_BYTES)) dut (.*);

	deframer_monitor #(.HEADER_BYTES(HEADER_BYTES)) mon (.*);

	always #5 clk = ~clk;

	// hard stop
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// receiver backpressure, a new pattern whenever rx_tick[6:0] wraps to zero
	always @(posedge clk) begin
		rx_tick <= rx_tick + 32'd1;
		if (rx_tick[6:0] == 7'd0)
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
		RX_OPEN:   out_ready <= 1'b1;
		RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
		RX_SPARSE: out_ready <= $urandom_range(0, 3) == 0;
		default:   out_ready <= rx_tick[2:0] != 3'd0;
		endcase
	end

	// one beat on the byte channel, with burst gaps in front of it
	task automatic push_byte(input logic [7:0] b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_byte <= b;
		do @(posedge clk); while (!in_ready);
		pushed++;
	endtask

	task automatic send_all();
		while (tx_q.size() != 0)
			push_byte(tx_q.pop_front());
	endtask

	// stop sending and let every forecast result come out
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_limit(input logic [31:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		limit_now = v;
		limits_written++;
	endtask

	task automatic add_byte(input logic [7:0] b);
		tx_q.push_back(b);
	endtask

	task automatic add_sync();
		add_byte(SYNC_B0);
		add_byte(SYNC_B1);
		add_byte(SYNC_B2);
		add_byte(SYNC_B3);
	endtask

	// little endian on the wire
	task automatic add_word(input logic [31:0] v);
		for (int i = 0; i < 4; i++)
			add_byte(v[8 * i +: 8]);
	endtask

	task automatic add_header(input logic [31:0] w, input logic [31:0] h,
			input logic [31:0] fps, input logic [31:0] rssi, input logic [31:0] scl,
			input logic [31:0] right, input logic [31:0] wrong,
			input logic [31:0] ie, input logic [31:0] iok);
		add_sync();
		add_word(w);
		add_word(h);
		add_word(fps);
		add_word(rssi);
		add_word(scl);
		add_word(right);
		add_word(wrong);
		add_word(ie);
		add_word(iok);
	endtask

	// flag words: half zero, else a single set bit anywhere or a random word
	function automatic logic [31:0] rand_flag();
		case ($urandom_range(0, 3))
		0, 1:    return 32'h0;
		2:       return 32'h1 << $urandom_range(0, 31);
		default: return $urandom;
		endcase
	endfunction

	task automatic add_random_header(input logic [31:0] w, input logic [31:0] h);
		add_header(w, h, $urandom, $urandom, rand_flag(), $urandom, $urandom,
			rand_flag(), rand_flag());
	endtask

	// payload with an occasional sync word that must pass straight through
	task automatic add_payload(input int n);
		int i;
		i = 0;
		while (i < n) begin
			if (n - i >= 4 && $urandom_range(0, 15) == 0) begin
				add_sync();
				i += 4;
			end else begin
				add_byte($urandom);
				i++;
			end
		end
	endtask

	// in clean phases noise never starts a sync word
	function automatic logic [7:0] noise_byte(input bit rough);
		logic [7:0] b;
		do b = $urandom; while (!rough && b == SYNC_B0);
		return b;
	endfunction

	function automatic logic [31:0] next_limit(input int p);
		case (p % 6)
		0:       return $urandom_range(4, 150);
		1:       return 32'd1;
		2:       return MAX_PAYLOAD_RESET;
		3:       return $urandom_range(3, 60);
		4:       return 32'hFFFF_FFFF;
		default: return ($urandom_range(0, 1) != 0) ? 32'd0 : 32'd2;
		endcase
	endfunction

	// one frame, accepted or rejected, with optional junk ahead of it
	task automatic random_frame(input bit rough);
		logic [31:0] w;
		logic [31:0] h;
		logic [31:0] q;
		int          n;
		int          pick;
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 6)) add_byte(noise_byte(rough));
		// cut-off header; the next sync word has to be found inside it
		if (rough && $urandom_range(0, 5) == 0) begin
			add_sync();
			repeat ($urandom_range(0, 30)) add_byte($urandom);
		end
		q = limit_now / 32'd3;
		pick = $urandom_range(0, 9);
		if (limit_now == 32'd0)
			pick = 9;
		else if (pick >= 3 && pick <= 5 && q == 32'd0)
			pick = 0;
		n = 0;
		if (pick <= 2) begin
			// compressed
			n = $urandom_range(1, (limit_now < 32'd40) ? limit_now : 32'd40);
			w = 32'd0;
			h = n;
		end else if (pick <= 5) begin
			// raw RGB
			w = $urandom_range(1, (q < 32'd4) ? q : 32'd4);
			h = $urandom_range(1, (q / w < 32'd4) ? q / w : 32'd4);
			n = 3 * w * h;
		end else begin
			case ($urandom_range(0, 4))
			0: begin
				w = 32'd0;
				h = 32'd0;
			end
			1: begin
				w = $urandom | 32'd1;
				h = 32'd0;
			end
			2: begin
				w = 32'd0;
				h = (limit_now > 32'hFFFF_0000) ? 32'd0 :
					limit_now + 32'd1 + $urandom_range(0, 999);
			end
			3: begin
				w = 32'd1;
				h = q + 32'd1;
			end
			default: begin
				w = 32'h1_0000 + $urandom_range(0, 255);
				h = 32'h1_0000 + $urandom_range(0, 255);
			end
			endcase
		end
		add_random_header(w, h);
		add_payload(n);
		send_all();
	endtask

	initial begin
		int stop_at;
		int phase_no;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// false start after noise, then a compressed frame with extreme fields
		add_byte(8'h00);
		add_byte(8'hFF);
		add_byte(SYNC_B0);
		add_byte(SYNC_B1);
		add_byte(SYNC_B2);
		add_header(32'd0, 32'd6, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 32'h0000_0100);
		add_byte(8'h00);
		add_byte(8'hFF);
		add_sync();
		// raw frame, one pixel, every header field clear
		add_header(32'd1, 32'd1, '0, '0, '0, '0, '0, '0, '0);
		add_byte(8'hA5);
		add_byte(8'h5A);
		add_byte(8'h00);
		// zero-length header whose tail carries the next sync word
		add_sync();
		add_word(32'd0);
		add_word(32'd0);
		add_random_header(32'd0, 32'd2);
		add_payload(2);
		// width*height beyond 32 bits, then a good raw frame right behind
		add_random_header(32'h1_0000, 32'h1_0000);
		add_random_header(32'd2, 32'd1);
		add_payload(6);
		send_all();

		// both length rules exactly at and one past the limit
		set_limit(32'd9);
		add_random_header(32'd1, 32'd3);
		add_payload(9);
		add_random_header(32'd1, 32'd4);
		add_random_header(32'd0, 32'd9);
		add_payload(9);
		add_random_header(32'd0, 32'd10);
		send_all();

		// zero limit rejects everything
		set_limit(32'd0);
		add_random_header(32'd0, 32'd1);
		add_random_header(32'd1, 32'd1);
		send_all();

		// widest limit: product above a third, zero height, then all-ones rssi, scale and counters
		set_limit(32'hFFFF_FFFF);
		add_random_header(32'hFFFF_FFFF, 32'd1);
		add_random_header(32'hFFFF_FFFF, 32'd0);
		add_header(32'd0, 32'd1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'h8000_0000, 32'h0100_0000);
		add_payload(1);
		send_all();

		// random phases, one limit setting each
		stop_at = pushed + RANDOM_BYTES;
		phase_no = 0;
		while (pushed < stop_at) begin
			set_limit(next_limit(phase_no));
			steady = $urandom_range(0, 3) == 0;
			repeat ($urandom_range(4, 9)) random_frame(limit_now < 32'h1_0000);
			phase_no++;
		end

		settle();
		repeat (8) @(posedge clk);
		$display("sent %0d stream bytes across %0d limit settings", pushed, limits_written);
		$display("checked %0d header beats and %0d payload beats", hdr_seen, bytes_seen);
		if (errors == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
